FILE: hdl/srcc_pkg.sv
package srcc_pkg;

  // Field widths of the item and result.
  localparam int unsigned SPEED_W = 13;
  localparam int unsigned CFG12_W = 12;
  localparam int unsigned MINP_W  = 10;
  localparam int unsigned HALF_W  = 19;
  localparam int unsigned MAG_W   = 12;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned EDGE_W  = 32;

  localparam logic [HALF_W-1:0] HALF_MAX = '1;

  // Item kinds carried in tuser.
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_RAMP  = 2'd1;
  localparam logic [1:0] KIND_MICRO = 2'd2;

  // Result kinds.
  localparam logic [1:0] RES_ACK    = 2'd0;
  localparam logic [1:0] RES_DISC   = 2'd1;
  localparam logic [1:0] RES_STATUS = 2'd2;

  localparam logic [7:0] MSG_COMMAND = 8'd0;
  localparam logic [7:0] NODE_BCAST  = 8'd0;

  // Command codes.
  localparam logic [7:0] OP_FWD     = 8'd2;
  localparam logic [7:0] OP_REV     = 8'd3;
  localparam logic [7:0] OP_HALT    = 8'd8;
  localparam logic [7:0] OP_SPEED   = 8'd9;
  localparam logic [7:0] OP_NODE_ID = 8'd10;
  localparam logic [7:0] OP_PROBE   = 8'd11;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAX_SPEED  = 3'd0;
  localparam logic [2:0] CFG_RAMP_STEP  = 3'd1;
  localparam logic [2:0] CFG_DEF_SPEED  = 3'd2;
  localparam logic [2:0] CFG_INVERT_DIR = 3'd3;
  localparam logic [2:0] CFG_MIN_PERIOD = 3'd4;

  localparam logic [CFG12_W-1:0] MAX_SPEED_RST  = 12'd2000;
  localparam logic [CFG12_W-1:0] RAMP_STEP_RST  = 12'd25;
  localparam logic [CFG12_W-1:0] DEF_SPEED_RST  = 12'd1500;
  localparam logic [MINP_W-1:0]  MIN_PERIOD_RST = 10'd50;
  localparam logic [ID_W-1:0]    OWN_ID_RST     = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_PUSH_DISC,
    ST_PUSH_ACK,
    ST_PUSH_STAT
  } state_e;

  typedef struct packed {
    logic [CFG12_W-1:0] max_speed;
    logic [CFG12_W-1:0] ramp_step;
    logic [CFG12_W-1:0] base_speed;
    logic               invert_direction;
    logic [MINP_W-1:0]  min_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         message_type;
    logic [7:0]         target_node;
    logic [7:0]         command_code;
    logic [7:0]         sequence_req;
    logic signed [15:0] parameter_req;
  } item_t;

  typedef struct packed {
    logic [1:0]                result_kind;
    logic [ID_W-1:0]           node_id;
    logic [7:0]                echo_sequence;
    logic                      step_level;
    logic                      direction_level;
    logic signed [SPEED_W-1:0] present_speed;
    logic [EDGE_W-1:0]         step_total;
    logic                      last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

FILE: hdl/srcc_div.sv
// Restoring divider with a constant numerator: one quotient bit per cycle.
module srcc_div #(
  parameter int unsigned NUMERATOR = 1000000,
  parameter int unsigned NUM_W     = 20,
  parameter int unsigned DEN_W     = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // The numerator register shifts out dividend bits at the top and takes
  // quotient bits in at the bottom.
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = NUM_W'(NUMERATOR);
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

FILE: hdl/srcc_core.sv
module srcc_core #(
  parameter int unsigned NUM_W = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srcc_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  srcc_pkg::item_t                in_item_i,
  output srcc_pkg::push_t                push_o,
  input  logic                           slot_free_i,
  output logic                           div_start_o,
  output logic [srcc_pkg::MAG_W-1:0]     div_den_o,
  input  logic                           div_done_i,
  input  logic [NUM_W-1:0]               div_quot_i
);

  import srcc_pkg::*;

  localparam int unsigned PW = (NUM_W > HALF_W + 1) ? NUM_W : HALF_W + 1;

  state_e state_q, state_d;
  item_t  item_q;

  logic signed [SPEED_W-1:0] target_q, target_d;
  logic signed [SPEED_W-1:0] cur_q, cur_d;
  logic [ID_W-1:0]           id_q, id_d;
  logic [HALF_W-1:0]         half_q, half_d;
  logic [HALF_W-1:0]         tick_q, tick_d;
  logic                      step_q, step_d;
  logic                      dir_q, dir_d;
  logic                      run_q, run_d;
  logic [EDGE_W-1:0]         edges_q, edges_d;

  logic                      accept;
  logic                      addressed;
  logic [CFG12_W-1:0]        delta;
  logic signed [14:0]        cur15, tgt15, sum15, dif15, nc15;
  logic signed [SPEED_W-1:0] nc;
  logic [SPEED_W-1:0]        nc_mag;
  logic signed [17:0]        p18, def18, pos_req, neg_req;
  logic [HALF_W-1:0]         tick_inc;
  logic                      step_new;
  logic [PW-1:0]             period, half_w;

  function automatic logic signed [SPEED_W-1:0] sat_target(logic signed [17:0] s,
                                                           logic [CFG12_W-1:0] lim);
    logic signed [17:0] lim18;
    logic signed [17:0] r;
    lim18 = signed'({6'b0, lim});
    r = s;
    if (r > lim18) r = lim18;
    if (r < -lim18) r = -lim18;
    return r[SPEED_W-1:0];
  endfunction

  assign accept    = in_valid_i && in_ready_o;
  assign addressed = (item_q.message_type == MSG_COMMAND)
                     && (item_q.target_node == NODE_BCAST || item_q.target_node == id_q);

  // Ramp arithmetic.
  assign delta = (cfg_i.ramp_step == '0) ? CFG12_W'(1) : cfg_i.ramp_step;
  assign cur15 = 15'(cur_q);
  assign tgt15 = 15'(target_q);
  assign sum15 = cur15 + signed'({3'b0, delta});
  assign dif15 = cur15 - signed'({3'b0, delta});

  always_comb begin
    if (tgt15 > cur15) begin
      nc15 = (sum15 > tgt15) ? tgt15 : sum15;
    end else if (tgt15 < cur15) begin
      nc15 = (dif15 < tgt15) ? tgt15 : dif15;
    end else begin
      nc15 = cur15;
    end
  end

  assign nc     = nc15[SPEED_W-1:0];
  assign nc_mag = nc[SPEED_W-1] ? SPEED_W'(-nc) : SPEED_W'(nc);

  // Command speed requests; the backward negation needs one extra bit.
  assign p18     = 18'(item_q.parameter_req);
  assign def18   = signed'({6'b0, cfg_i.base_speed});
  assign pos_req = (p18 != 18'sd0) ? p18 : def18;
  assign neg_req = (p18 != 18'sd0) ? -p18 : -def18;

  assign tick_inc = tick_q + HALF_W'(1);
  assign step_new = ~step_q;

  // Full period from the quotient, raised to the minimum, then halved.
  always_comb begin
    period = PW'(div_quot_i);
    if (period < PW'(cfg_i.min_period)) begin
      period = PW'(cfg_i.min_period);
    end
    half_w = period >> 1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (item_q.kind)
          KIND_RAMP:  state_d = (nc != '0) ? ST_DIV : ST_PUSH_STAT;
          KIND_MICRO: state_d = ST_PUSH_STAT;
          KIND_CMD: begin
            if (!addressed) begin
              state_d = ST_IDLE;
            end else if (item_q.command_code == OP_PROBE) begin
              state_d = ST_PUSH_DISC;
            end else begin
              state_d = ST_PUSH_ACK;
            end
          end
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (div_done_i) state_d = ST_PUSH_STAT;
      end
      ST_PUSH_DISC: begin
        if (slot_free_i) state_d = ST_PUSH_ACK;
      end
      ST_PUSH_ACK, ST_PUSH_STAT: begin
        if (slot_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    target_d    = target_q;
    cur_d       = cur_q;
    id_d        = id_q;
    half_d      = half_q;
    tick_d      = tick_q;
    step_d      = step_q;
    dir_d       = dir_q;
    run_d       = run_q;
    edges_d     = edges_q;
    div_start_o = 1'b0;
    if (state_q == ST_EXEC) begin
      case (item_q.kind)
        KIND_RAMP: begin
          cur_d = nc;
          if (nc != '0) begin
            dir_d       = (!nc[SPEED_W-1]) ^ cfg_i.invert_direction;
            run_d       = 1'b1;
            div_start_o = 1'b1;
          end else begin
            run_d  = 1'b0;
            step_d = 1'b0;
          end
        end
        KIND_MICRO: begin
          if (run_q) begin
            if (tick_inc >= half_q) begin
              tick_d = '0;
              step_d = step_new;
              if (step_new) edges_d = edges_q + EDGE_W'(1);
            end else begin
              tick_d = tick_inc;
            end
          end
        end
        KIND_CMD: begin
          if (addressed) begin
            case (item_q.command_code)
              OP_FWD:   target_d = sat_target(pos_req, cfg_i.max_speed);
              OP_REV:   target_d = sat_target(neg_req, cfg_i.max_speed);
              OP_HALT:  target_d = '0;
              OP_SPEED: target_d = sat_target(p18, cfg_i.max_speed);
              OP_NODE_ID: begin
                if (item_q.parameter_req > 16'sd0 && item_q.parameter_req <= 16'sd255) begin
                  id_d = item_q.parameter_req[ID_W-1:0];
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
    if (state_q == ST_DIV && div_done_i) begin
      half_d = (half_w > PW'(HALF_MAX)) ? HALF_MAX : half_w[HALF_W-1:0];
    end
  end

  assign div_den_o = nc_mag[MAG_W-1:0];

  // Outputs.
  always_comb begin
    in_ready_o                 = 1'b0;
    push_o.valid               = 1'b0;
    push_o.res.result_kind     = RES_STATUS;
    push_o.res.node_id         = id_q;
    push_o.res.echo_sequence   = '0;
    push_o.res.step_level      = step_q;
    push_o.res.direction_level = dir_q;
    push_o.res.present_speed   = cur_q;
    push_o.res.step_total      = edges_q;
    push_o.res.last            = 1'b1;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_PUSH_DISC: begin
        push_o.valid           = 1'b1;
        push_o.res.result_kind = RES_DISC;
        push_o.res.last        = 1'b0;
      end
      ST_PUSH_ACK: begin
        push_o.valid             = 1'b1;
        push_o.res.result_kind   = RES_ACK;
        push_o.res.echo_sequence = item_q.sequence_req;
      end
      ST_PUSH_STAT: push_o.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      target_q <= '0;
      cur_q    <= '0;
      id_q     <= OWN_ID_RST;
      half_q   <= '0;
      tick_q   <= '0;
      step_q   <= 1'b0;
      dir_q    <= 1'b1;
      run_q    <= 1'b0;
      edges_q  <= '0;
    end else begin
      state_q  <= state_d;
      target_q <= target_d;
      cur_q    <= cur_d;
      id_q     <= id_d;
      half_q   <= half_d;
      tick_q   <= tick_d;
      step_q   <= step_d;
      dir_q    <= dir_d;
      run_q    <= run_d;
      edges_q  <= edges_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

endmodule

FILE: hdl/stepper_ramp_command_controller.sv
// Stepper ramp command controller.
//
// The input stream carries one item per beat; tuser holds the kind (command
// packet, ramp tick, microsecond tick) and tdata the packet fields. The
// output stream carries acknowledges, discovery responses and motor status;
// tuser holds the result kind and tlast marks the final result of an item.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i. The
// user must write it only while idle; the block itself does not enforce it.
//
// Items are handled one at a time. A command packet, a microsecond tick or a
// ramp tick that leaves the speed at zero goes from the execute state to a
// push state, which loads its result into the output register once that
// register is free; the block then returns to idle and takes the next beat.
// A discover command loads a discovery response, then its acknowledge. A
// ramp tick that leaves a nonzero speed runs the bit-serial period divider,
// one quotient bit per cycle, before it loads its status. Dropped packets
// return from the execute state to idle and give no beat. Reset clears the
// speeds and step counters, sets node id 1 and loads the register defaults.
// A stalled receiver holds the result in the one-deep output register; the
// next item may be accepted meanwhile and its results wait for that register.
module stepper_ramp_command_controller #(
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // message_type, target_node, command_code, sequence_req, parameter_req
  input  logic [47:0] s_axis_tdata,
  // kind
  input  logic [1:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // node_id, echo_sequence, step_level, direction_level, present_speed,
  // step_total, one zero pad bit
  output logic [63:0] m_axis_tdata,
  // result_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  import srcc_pkg::*;

  localparam int unsigned NUM_W = $clog2(TICKS_PER_SECOND + 1);

  cfg_t    cfg_q, cfg_d;
  item_t   item;
  push_t   push;
  result_t out_q;
  logic    out_valid_q, out_valid_d;
  logic    slot_free;
  logic    div_start, div_done;
  logic [MAG_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_SPEED:  cfg_d.max_speed        = cfg_data_i;
        CFG_RAMP_STEP:  cfg_d.ramp_step        = cfg_data_i;
        CFG_DEF_SPEED:  cfg_d.base_speed       = cfg_data_i;
        CFG_INVERT_DIR: cfg_d.invert_direction = cfg_data_i[0];
        CFG_MIN_PERIOD: cfg_d.min_period       = cfg_data_i[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.kind          = s_axis_tuser;
  assign item.message_type  = s_axis_tdata[7:0];
  assign item.target_node   = s_axis_tdata[15:8];
  assign item.command_code  = s_axis_tdata[23:16];
  assign item.sequence_req  = s_axis_tdata[31:24];
  assign item.parameter_req = s_axis_tdata[47:32];

  srcc_div #(
    .NUMERATOR (TICKS_PER_SECOND),
    .NUM_W     (NUM_W),
    .DEN_W     (MAG_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  srcc_core #(
    .NUM_W (NUM_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .push_o      (push),
    .slot_free_i (slot_free),
    .div_start_o (div_start),
    .div_den_o   (div_den),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot)
  );

  // One-deep output register between the core and the receiver.
  assign slot_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push.valid && slot_free) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q            <= 1'b0;
      cfg_q.max_speed        <= MAX_SPEED_RST;
      cfg_q.ramp_step        <= RAMP_STEP_RST;
      cfg_q.base_speed       <= DEF_SPEED_RST;
      cfg_q.invert_direction <= 1'b0;
      cfg_q.min_period       <= MIN_PERIOD_RST;
    end else begin
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid && slot_free) begin
      out_q <= push.res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {1'b0, out_q.step_total, out_q.present_speed,
                          out_q.direction_level, out_q.step_level,
                          out_q.echo_sequence, out_q.node_id};

endmodule

FILE: hdl/srcc_checker.sv
module srcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  import srcc_pkg::*;

  // Set after a discovery response beat, cleared by the acknowledge.
  logic disc_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      disc_seen_q <= !m_axis_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_nonlast_is_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == RES_DISC && !s_axis_tready)
    else $error("non-final beat is not a discovery response or input not held off");

  a_ack_follows_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_seen_q && m_axis_tvalid |-> m_axis_tuser == RES_ACK && m_axis_tlast)
    else $error("discovery response not followed by its acknowledge");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == RES_STATUS |-> m_axis_tdata[15:8] == 8'd0
                                                   && m_axis_tlast)
    else $error("status beat carries a sequence number or is not final");

endmodule

bind stepper_ramp_command_controller srcc_checker u_srcc_checker (.*);
